FILE: hdl/sobel_pkg.sv
// shared types and constants for the sobel edge magnitude block
// no dependencies; used by sobel_root and sobel_edge_magnitude_rgb
`timescale 1ns / 1ps
`default_nettype none
package sobel_pkg;
  localparam int unsigned PixW    = 8;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PosW    = 24;
  localparam int unsigned SqW     = 22;
  localparam int unsigned GradW   = 12;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;

  typedef logic [RgbW-1:0] rgb_t;
  typedef logic signed [GradW-1:0] grad_t;
endpackage
`default_nettype wire

FILE: hdl/sobel_root.sv
// iterative rounded integer square root, two bits of the radicand per cycle
// depends on sobel_pkg; result saturated at 255
`timescale 1ns / 1ps
`default_nettype none
module sobel_root (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sobel_pkg::SqW-1:0] value_i,
  output logic                           done_o,
  output logic [sobel_pkg::PixW-1:0]     mag_o
);
  logic [sobel_pkg::SqW-1:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [sobel_pkg::SqW-1:0] trial, root_rnd;
  logic busy_q, busy_d, done_q, done_d;

  // one restoring step per cycle
  always_comb begin
    trial  = root_q + bit_q;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      root_d = '0;
      bit_d  = sobel_pkg::SqW'(1) << (sobel_pkg::SqW - 2);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == sobel_pkg::SqW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  // round up when the remainder exceeds the root, then saturate
  assign root_rnd = (rem_q > root_q) ? root_q + sobel_pkg::SqW'(1) : root_q;
  assign mag_o    = (root_rnd > sobel_pkg::SqW'(255)) ? 8'd255 : root_rnd[7:0];
  assign done_o   = done_q;
endmodule
`default_nettype wire

FILE: hdl/sobel_edge_magnitude_rgb.sv
// sobel gradient magnitude per color channel on a raster rgb pixel stream
// depends on sobel_pkg and sobel_root
//
// channel | direction | beat contents
// --------+-----------+------------------------------------------
// in      | sink      | kind_i, red_in_i, green_in_i, blue_in_i
// out     | source    | red_out_o, green_out_o, blue_out_o, last_pixel_o
// cfg     | sink      | cfg_index_i, cfg_data_i
//
// an input beat that causes no output leaves the input ready; one that causes an
// output holds the input off through the accepting cycle, the window reads from
// the row memory, a sum and a square stage, the root steps (load, restoring
// steps, done) and the output load.
// reset clears counters and control; the row memory holds no reset value.
// a full output register stalls the sequencer before its load step only.
`timescale 1ns / 1ps
`default_nettype none
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic [sobel_pkg::PixW-1:0]    red_in_i,
  input  wire logic [sobel_pkg::PixW-1:0]    green_in_i,
  input  wire logic [sobel_pkg::PixW-1:0]    blue_in_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [sobel_pkg::PixW-1:0]         red_out_o,
  output logic [sobel_pkg::PixW-1:0]         green_out_o,
  output logic [sobel_pkg::PixW-1:0]         blue_out_o,
  output logic                               last_pixel_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sobel_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [sobel_pkg::CfgW-1:0]    cfg_data_i
);
  localparam int unsigned Depth = 3 * MAX_WIDTH;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PosW  = sobel_pkg::PosW;
  localparam int unsigned WW    = sobel_pkg::WidthW;
  localparam int unsigned HW    = sobel_pkg::HeightW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [WW-1:0] width_q, eff_w;
  logic [HW-1:0] height_q, eff_h;
  logic [PosW-1:0] total;
  logic [PosW-1:0] in_pos_q, in_pos_d, out_pos_q, out_pos_d;
  logic [WW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [1:0] in_m3_q, in_m3_d, out_m3_q, out_m3_d;
  logic [HW-1:0] out_row_q, out_row_d;
  logic [3:0] tap_q, tap_d, rd_tap_q;
  logic [1:0] ka_q, ka_d, kb_q, kb_d;
  logic rd_pend_q, rd_zero_q, rd_issue, tap_ok;
  logic [2:0] sel_sum;
  logic [1:0] sel;
  logic [WW-1:0] col_tap;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic wr_en, in_acc, cfg_acc, cfg_restart, pix_store, emit_go, out_load;
  sobel_pkg::rgb_t mem_q [Depth];
  sobel_pkg::rgb_t rd_data_q, wr_data;
  sobel_pkg::rgb_t win_q [9];
  sobel_pkg::grad_t gx_q [3], gy_q [3];
  logic [sobel_pkg::SqW-1:0] sq_q [3];
  logic [sobel_pkg::PixW-1:0] mag [3];
  logic root_start_q;
  logic [2:0] root_done;
  logic out_valid_q;
  logic [sobel_pkg::PixW-1:0] red_q, green_q, blue_q;
  logic last_q;

  // clamped geometry
  always_comb begin
    if (width_q == '0) eff_w = WW'(1);
    else if (int'(width_q) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = width_q;
    if (height_q == '0) eff_h = HW'(1);
    else if (int'(height_q) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else eff_h = height_q;
  end
  assign total = PosW'(eff_w) * PosW'(eff_h);

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign cfg_restart = cfg_acc && (cfg_index_i == sobel_pkg::RegWidth ||
                                   cfg_index_i == sobel_pkg::RegHeight);
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign pix_store   = in_acc && !kind_i && (in_pos_q < total);

  // row memory write for an incoming pixel
  assign wr_en   = pix_store;
  assign wr_data = {red_in_i, green_in_i, blue_in_i};
  assign wr_addr = AddrW'(in_m3_q * MAX_WIDTH) + AddrW'(in_col_q);

  // window tap address and border test
  always_comb begin
    sel_sum = 3'(out_m3_q) + 3'(ka_q) + 3'd2;
    if (sel_sum >= 3'd6) sel = 2'(sel_sum - 3'd6);
    else if (sel_sum >= 3'd3) sel = 2'(sel_sum - 3'd3);
    else sel = sel_sum[1:0];
    col_tap = out_col_q + WW'(kb_q) - WW'(1);
    tap_ok  = !((ka_q == 2'd0) && (out_row_q == '0)) &&
              !((ka_q == 2'd2) && ({1'b0, out_row_q} + 14'd1 >= {1'b0, eff_h})) &&
              !((kb_q == 2'd0) && (out_col_q == '0)) &&
              !((kb_q == 2'd2) && ({1'b0, out_col_q} + 12'd1 >= {1'b0, eff_w}));
    rd_addr = AddrW'(sel * MAX_WIDTH) + AddrW'(col_tap);
  end
  assign rd_issue = (state_q == S_READ) && (tap_q < 4'd9);

  // single-port style row memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  // sequencer and position counters
  always_comb begin
    state_d   = state_q;
    in_pos_d  = in_pos_q;
    in_col_d  = in_col_q;
    in_m3_d   = in_m3_q;
    out_pos_d = out_pos_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    out_m3_d  = out_m3_q;
    tap_d     = tap_q;
    ka_d      = ka_q;
    kb_d      = kb_q;
    emit_go   = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (pix_store) begin
            in_pos_d = in_pos_q + PosW'(1);
            if ({1'b0, in_col_q} + 12'd1 >= {1'b0, eff_w}) begin
              in_col_d = '0;
              in_m3_d  = (in_m3_q == 2'd2) ? 2'd0 : in_m3_q + 2'd1;
            end else begin
              in_col_d = in_col_q + WW'(1);
            end
            emit_go = ({1'b0, in_pos_q} + 25'd1) >=
                      ({1'b0, out_pos_q} + 25'(eff_w) + 25'd2);
          end else begin
            emit_go = (in_pos_q >= total) && (out_pos_q < total);
          end
          if (emit_go) begin
            state_d = S_READ;
            tap_d   = '0;
            ka_d    = '0;
            kb_d    = '0;
          end
        end
      end
      S_READ: begin
        if (tap_q == 4'd9) begin
          state_d = S_SUM;
        end else begin
          tap_d = tap_q + 4'd1;
          if (kb_q == 2'd2) begin
            kb_d = '0;
            ka_d = ka_q + 2'd1;
          end else begin
            kb_d = kb_q + 2'd1;
          end
        end
      end
      S_SUM: state_d = S_SQ;
      S_SQ: state_d = S_ROOT;
      S_ROOT: if (&root_done) state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (out_pos_q + PosW'(1) >= total) begin
            in_pos_d  = '0;
            in_col_d  = '0;
            in_m3_d   = '0;
            out_pos_d = '0;
            out_col_d = '0;
            out_row_d = '0;
            out_m3_d  = '0;
          end else begin
            out_pos_d = out_pos_q + PosW'(1);
            if ({1'b0, out_col_q} + 12'd1 >= {1'b0, eff_w}) begin
              out_col_d = '0;
              out_row_d = out_row_q + HW'(1);
              out_m3_d  = (out_m3_q == 2'd2) ? 2'd0 : out_m3_q + 2'd1;
            end else begin
              out_col_d = out_col_q + WW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a write to a defined register restarts the image
    if (cfg_restart) begin
      in_pos_d  = '0;
      in_col_d  = '0;
      in_m3_d   = '0;
      out_pos_d = '0;
      out_col_d = '0;
      out_row_d = '0;
      out_m3_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= WW'(640);
      height_q    <= HW'(480);
      in_pos_q    <= '0;
      in_col_q    <= '0;
      in_m3_q     <= '0;
      out_pos_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_m3_q    <= '0;
      tap_q       <= '0;
      ka_q        <= '0;
      kb_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_pos_q  <= in_pos_d;
      in_col_q  <= in_col_d;
      in_m3_q   <= in_m3_d;
      out_pos_q <= out_pos_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      out_m3_q  <= out_m3_d;
      tap_q     <= tap_d;
      ka_q      <= ka_d;
      kb_q      <= kb_d;
      rd_pend_q <= rd_issue;
      if (cfg_acc && cfg_index_i == sobel_pkg::RegWidth) width_q <= cfg_data_i[WW-1:0];
      if (cfg_acc && cfg_index_i == sobel_pkg::RegHeight) height_q <= cfg_data_i[HW-1:0];
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // window capture, one tap per cycle behind the read
  always_ff @(posedge clk_i) begin
    rd_tap_q  <= tap_q;
    rd_zero_q <= !tap_ok;
    if (rd_pend_q) win_q[rd_tap_q] <= rd_zero_q ? '0 : rd_data_q;
  end

  // root units start together once the squares are in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) root_start_q <= 1'b0;
    else root_start_q <= (state_q == S_SQ);
  end

  // gradients, squares and the root units per channel
  for (genvar c = 0; c < 3; c++) begin : g_ch
    localparam int unsigned Hi = sobel_pkg::RgbW - 1 - 8 * c;
    sobel_pkg::grad_t p [9];
    for (genvar k = 0; k < 9; k++) begin : g_px
      assign p[k] = sobel_pkg::GradW'({4'b0, win_q[k][Hi -: 8]});
    end
    always_ff @(posedge clk_i) begin
      if (state_q == S_SUM) begin
        gx_q[c] <= p[2] - p[0] + ((p[5] - p[3]) <<< 1) + p[8] - p[6];
        gy_q[c] <= p[6] - p[0] + ((p[7] - p[1]) <<< 1) + p[8] - p[2];
      end
      if (state_q == S_SQ) begin
        sq_q[c] <= sobel_pkg::SqW'(24'(gx_q[c] * gx_q[c]) + 24'(gy_q[c] * gy_q[c]));
      end
    end
    sobel_root u_root (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (root_start_q),
      .value_i (sq_q[c]),
      .done_o  (root_done[c]),
      .mag_o   (mag[c])
    );
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= mag[0];
      green_q <= mag[1];
      blue_q  <= mag[2];
      last_q  <= (out_pos_q + PosW'(1) == total);
    end
  end
  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign last_pixel_o = last_q;

  // checks
  a_in_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pos_q <= total) else $error("input position beyond image");
  a_out_behind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_pos_q <= in_pos_q) else $error("output position ahead of input");
  a_root_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    |root_done |-> state_q == S_ROOT) else $error("root done outside root step");
  a_load_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> state_q == S_IDLE && out_valid_q) else $error("output load lost");
endmodule
`default_nettype wire
